FILE: hw/rtl/acl_pkg.sv
`timescale 1ns / 1ps
// Shared types, codes and helpers for the access-list decision block.
// No dependencies; used by acl_group_match and acl_access_decision.
package acl_pkg;

	localparam int GROUP_SLOTS_DEF = 16;
	localparam int ID_W            = 32;
	localparam int SLOT_W          = 4;
	localparam int COUNT_W         = 5;
	localparam int MODE_W          = 9;
	localparam int PERM_W          = 3;
	localparam int TAG_W           = 3;
	localparam int REASON_W        = 3;
	localparam int OPSEL_W         = 2;
	localparam int CFG_IDX_W       = 3;
	localparam int CFG_DATA_W      = 32;
	localparam int IN_DATA_W       = 48;
	localparam int OUT_DATA_W      = 8;

	localparam int OWNER_SHIFT = 6;
	localparam int GROUP_SHIFT = 3;

	localparam logic OP_LOAD  = 1'b0;
	localparam logic OP_ENTRY = 1'b1;

	localparam logic [TAG_W-1:0] TAG_OWNER       = 3'd0;
	localparam logic [TAG_W-1:0] TAG_NAMED_USER  = 3'd1;
	localparam logic [TAG_W-1:0] TAG_OWNING_GRP  = 3'd2;
	localparam logic [TAG_W-1:0] TAG_NAMED_GRP   = 3'd3;
	localparam logic [TAG_W-1:0] TAG_MASK        = 3'd4;
	localparam logic [TAG_W-1:0] TAG_OTHER       = 3'd5;

	localparam logic [OPSEL_W-1:0] REQ_READ  = 2'd0;
	localparam logic [OPSEL_W-1:0] REQ_WRITE = 2'd1;
	localparam logic [OPSEL_W-1:0] REQ_EXEC  = 2'd2;

	localparam logic [REASON_W-1:0] RSN_NONE          = 3'd0;
	localparam logic [REASON_W-1:0] RSN_OWNER_DENIED  = 3'd1;
	localparam logic [REASON_W-1:0] RSN_LIST_DENIED   = 3'd2;
	localparam logic [REASON_W-1:0] RSN_GROUP_MISSING = 3'd3;
	localparam logic [REASON_W-1:0] RSN_OTHER_DENIED  = 3'd4;

	localparam logic [CFG_IDX_W-1:0] REG_REQUEST_OP     = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_REQUESTER_UID  = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_FILE_OWNER_UID = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_FILE_GROUP_GID = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_FILE_MODE_BITS = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_GROUP_COUNT    = 3'd5;

	// bit 0: matching entry seen, bit 1: that entry allows the request
	localparam int FLAG_SEEN  = 0;
	localparam int FLAG_ALLOW = 1;

	typedef struct packed {
		logic [PERM_W-1:0] mask;
		logic [1:0]        owner;
		logic [1:0]        named;
		logic [1:0]        group;
		logic [1:0]        other;
	} findings_t;

	localparam findings_t FINDINGS_CLEAR = '{mask: 3'b111, owner: 2'b00, named: 2'b00,
		group: 2'b00, other: 2'b00};

	typedef struct packed {
		logic            en;
		logic [SLOT_W-1:0] slot;
		logic [ID_W-1:0]   id;
	} load_req_t;

	function automatic logic perms_grant(input logic [PERM_W-1:0] perms,
		input logic [OPSEL_W-1:0] op);
		logic [PERM_W-1:0] bit_sel;
		begin
			case (op)
				REQ_READ:  bit_sel = 3'b100;
				REQ_WRITE: bit_sel = 3'b010;
				REQ_EXEC:  bit_sel = 3'b001;
				default:   bit_sel = 3'b000;
			endcase
			return (perms & bit_sel) != '0;
		end
	endfunction

endpackage

FILE: hw/rtl/acl_group_match.sv
`timescale 1ns / 1ps
// Requester group table with a parallel membership compare.
// Depends on acl_pkg.
module acl_group_match #(
	parameter int GROUP_SLOTS = acl_pkg::GROUP_SLOTS_DEF
) (
	input  logic                         clk,
	input  acl_pkg::load_req_t           load,
	input  logic [acl_pkg::COUNT_W-1:0]  group_count,
	input  logic [acl_pkg::ID_W-1:0]     match_gid,
	output logic                         hit
);
	import acl_pkg::*;

	logic [ID_W-1:0] tbl_q [GROUP_SLOTS];

	always_ff @(posedge clk) begin
		for (int i = 0; i < GROUP_SLOTS; i++) begin
			if (load.en && (32'(load.slot) == 32'(i))) begin
				tbl_q[i] <= load.id;
			end
		end
	end

	always_comb begin
		hit = 1'b0;
		for (int i = 0; i < GROUP_SLOTS; i++) begin
			if ((tbl_q[i] == match_gid) && ({27'd0, group_count} > 32'(i))) begin
				hit = 1'b1;
			end
		end
	end

endmodule

FILE: hw/rtl/acl_access_decision.sv
`timescale 1ns / 1ps
// Access-list decision: top level. Depends on acl_pkg and acl_group_match.
// Results are registered. Throughput: one request per cycle while the output
// is not stalled; the path is the tag decode plus the parallel compare over all
// group slots between input and result registers.
// Reset clears configuration, findings and valids; the group table is not reset.
module acl_access_decision #(
	parameter int GROUP_SLOTS = acl_pkg::GROUP_SLOTS_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            s_axis_tvalid,
	output logic                            s_axis_tready,
	// slot_index[3:0], identifier[35:4], entry_tag[38:36], entry_perms[41:39]
	input  logic [acl_pkg::IN_DATA_W-1:0]   s_axis_tdata,
	// operation[0]
	input  logic                            s_axis_tuser,
	input  logic                            s_axis_tlast,
	output logic                            m_axis_tvalid,
	input  logic                            m_axis_tready,
	// allowed[0], reason[3:1]
	output logic [acl_pkg::OUT_DATA_W-1:0]  m_axis_tdata,
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [acl_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [acl_pkg::CFG_DATA_W-1:0]  cfg_data
);
	import acl_pkg::*;

	logic [OPSEL_W-1:0] request_op_q;
	logic [ID_W-1:0]    requester_uid_q;
	logic [ID_W-1:0]    file_owner_uid_q;
	logic [ID_W-1:0]    file_group_gid_q;
	logic [MODE_W-1:0]  file_mode_q;
	logic [COUNT_W-1:0] group_count_q;

	logic              valid_s1;
	logic              op_s1;
	logic [SLOT_W-1:0] slot_s1;
	logic [ID_W-1:0]   ident_s1;
	logic [TAG_W-1:0]  tag_s1;
	logic [PERM_W-1:0] perms_s1;
	logic              last_s1;

	findings_t          find_q;
	findings_t          find_next;
	logic               m_valid_q;
	logic               allowed_q;
	logic [REASON_W-1:0] reason_q;

	logic               emit_s1;
	logic               out_free;
	logic               adv_s1;
	logic               grant_s1;
	logic               group_hit;
	logic [ID_W-1:0]    match_gid;
	load_req_t          load;
	logic               mask_ok;
	logic               ok;
	logic [REASON_W-1:0] reason;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			request_op_q     <= '0;
			requester_uid_q  <= '0;
			file_owner_uid_q <= '0;
			file_group_gid_q <= '0;
			file_mode_q      <= '0;
			group_count_q    <= '0;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_REQUEST_OP:     request_op_q     <= cfg_data[OPSEL_W-1:0];
				REG_REQUESTER_UID:  requester_uid_q  <= cfg_data[ID_W-1:0];
				REG_FILE_OWNER_UID: file_owner_uid_q <= cfg_data[ID_W-1:0];
				REG_FILE_GROUP_GID: file_group_gid_q <= cfg_data[ID_W-1:0];
				REG_FILE_MODE_BITS: file_mode_q      <= cfg_data[MODE_W-1:0];
				REG_GROUP_COUNT:    group_count_q    <= cfg_data[COUNT_W-1:0];
				default: ;
			endcase
		end
	end

	assign emit_s1       = valid_s1 && (op_s1 == OP_ENTRY) && last_s1;
	assign out_free      = !m_valid_q || m_axis_tready;
	assign adv_s1        = valid_s1 && (!emit_s1 || out_free);
	assign s_axis_tready = !valid_s1 || adv_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tready && s_axis_tvalid) begin
			op_s1    <= s_axis_tuser;
			slot_s1  <= s_axis_tdata[3:0];
			ident_s1 <= s_axis_tdata[35:4];
			tag_s1   <= s_axis_tdata[38:36];
			perms_s1 <= s_axis_tdata[41:39];
			last_s1  <= s_axis_tlast;
		end
	end

	assign load.en   = adv_s1 && (op_s1 == OP_LOAD) && (32'(slot_s1) < 32'(GROUP_SLOTS));
	assign load.slot = slot_s1;
	assign load.id   = ident_s1;
	assign match_gid = (tag_s1 == TAG_OWNING_GRP) ? file_group_gid_q : ident_s1;

	acl_group_match #(
		.GROUP_SLOTS(GROUP_SLOTS)
	) u_group_match (
		.clk        (clk),
		.load       (load),
		.group_count(group_count_q),
		.match_gid  (match_gid),
		.hit        (group_hit)
	);

	assign grant_s1 = perms_grant(perms_s1, request_op_q);

	always_comb begin
		find_next = find_q;
		unique case (tag_s1) inside
			TAG_OWNER: find_next.owner = {grant_s1, 1'b1};
			TAG_NAMED_USER: begin
				if (ident_s1 == requester_uid_q) begin
					find_next.named = {grant_s1, 1'b1};
				end
			end
			TAG_OWNING_GRP, TAG_NAMED_GRP: begin
				if (group_hit) begin
					find_next.group[FLAG_SEEN]  = 1'b1;
					find_next.group[FLAG_ALLOW] = find_q.group[FLAG_ALLOW] | grant_s1;
				end
			end
			TAG_MASK:  find_next.mask  = perms_s1;
			TAG_OTHER: find_next.other = {grant_s1, 1'b1};
			default: ;
		endcase
	end

	always_comb begin
		mask_ok = perms_grant(find_next.mask, request_op_q);
		if (requester_uid_q == file_owner_uid_q) begin
			ok = find_next.owner[FLAG_SEEN] ? find_next.owner[FLAG_ALLOW]
				: perms_grant(file_mode_q[OWNER_SHIFT +: PERM_W], request_op_q);
			reason = ok ? RSN_NONE : RSN_OWNER_DENIED;
		end else if (find_next.named[FLAG_SEEN]) begin
			ok     = find_next.named[FLAG_ALLOW] && mask_ok;
			reason = ok ? RSN_NONE : RSN_LIST_DENIED;
		end else if (find_next.group[FLAG_SEEN]) begin
			ok     = find_next.group[FLAG_ALLOW] && mask_ok;
			reason = ok ? RSN_NONE : RSN_LIST_DENIED;
		end else begin
			ok = find_next.other[FLAG_SEEN] && find_next.other[FLAG_ALLOW];
			if (ok) begin
				reason = RSN_NONE;
			end else if (perms_grant(file_mode_q[GROUP_SHIFT +: PERM_W], request_op_q)) begin
				reason = RSN_GROUP_MISSING;
			end else begin
				reason = RSN_OTHER_DENIED;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			find_q <= FINDINGS_CLEAR;
		end else if (adv_s1 && (op_s1 == OP_ENTRY)) begin
			find_q <= last_s1 ? FINDINGS_CLEAR : find_next;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (out_free) begin
			m_valid_q <= adv_s1 && emit_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1 && emit_s1) begin
			allowed_q <= ok;
			reason_q  <= reason;
		end
	end

	assign m_axis_tvalid = m_valid_q;
	assign m_axis_tdata  = {4'd0, reason_q, allowed_q};

endmodule

FILE: tb/tb_acl_access_decision.sv
`timescale 1ns / 1ps
// Self-checking bench for acl_access_decision: directed and random access-list
// streams, with group-slot loads and register settings, scored by an in-bench
// decision predictor. Depends on acl_pkg and the acl_access_decision RTL.
module tb_acl_access_decision;
	import acl_pkg::*;

	localparam int SLOTS        = GROUP_SLOTS_DEF;
	localparam int RANDOM_ITEMS = 1500;
	localparam int DRAIN_CYCLES = 4;
	localparam int HOLD_CYCLES  = 300;
	localparam int PAD_W        = IN_DATA_W - PERM_W - TAG_W - ID_W - SLOT_W;

	localparam logic [TAG_W-1:0]   TAG_IGNORED   = 3'd6;
	localparam logic [TAG_W-1:0]   TAG_RESERVED  = 3'd7;
	localparam logic [OPSEL_W-1:0] REQ_UNDEFINED = 2'd3;

	typedef struct {
		logic                allowed;
		logic [REASON_W-1:0] reason;
	} decision_t;

	logic                   clk;
	logic                   arst_n;
	logic                   s_axis_tvalid;
	logic                   s_axis_tready;
	logic [IN_DATA_W-1:0]   s_axis_tdata;
	logic                   s_axis_tuser;
	logic                   s_axis_tlast;
	logic                   m_axis_tvalid;
	logic                   m_axis_tready;
	logic [OUT_DATA_W-1:0]  m_axis_tdata;
	logic                   cfg_valid;
	logic                   cfg_ready;
	logic [CFG_IDX_W-1:0]   cfg_index;
	logic [CFG_DATA_W-1:0]  cfg_data;

	logic [OPSEL_W-1:0] req_op;
	logic [ID_W-1:0]    req_uid;
	logic [ID_W-1:0]    own_uid;
	logic [ID_W-1:0]    own_gid;
	logic [MODE_W-1:0]  mode_bits;
	logic [COUNT_W-1:0] grp_count;
	logic [ID_W-1:0]    member_gid [SLOTS];
	logic [PERM_W-1:0]  mask_perms;
	logic owner_seen, owner_ok, named_seen, named_ok;
	logic grp_seen, grp_ok, other_seen, other_ok;

	decision_t decision_q[$];
	int        sent_cnt;
	int        error_cnt;
	int        hold_len;
	bit        idle_on;

	acl_access_decision #(
		.GROUP_SLOTS(SLOTS)
	) uut (
		.clk          (clk),
		.arst_n       (arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata (s_axis_tdata),
		.s_axis_tuser (s_axis_tuser),
		.s_axis_tlast (s_axis_tlast),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata (m_axis_tdata),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	always begin
		clk = 1'b0;
		#6;
		clk = 1'b1;
		#6;
	end

	function automatic logic op_granted(input logic [PERM_W-1:0] perms);
		case (req_op)
			REQ_READ:  return perms[2];
			REQ_WRITE: return perms[1];
			REQ_EXEC:  return perms[0];
			default:   return 1'b0;
		endcase
	endfunction

	function automatic logic is_member(input logic [ID_W-1:0] gid);
		int n;
		n = (grp_count > SLOTS) ? SLOTS : int'(grp_count);
		for (int i = 0; i < n; i++)
			if (member_gid[i] == gid)
				return 1'b1;
		return 1'b0;
	endfunction

	function automatic void clear_findings();
		mask_perms = '1;
		owner_seen = 1'b0;
		owner_ok   = 1'b0;
		named_seen = 1'b0;
		named_ok   = 1'b0;
		grp_seen   = 1'b0;
		grp_ok     = 1'b0;
		other_seen = 1'b0;
		other_ok   = 1'b0;
	endfunction

	function automatic logic [ID_W-1:0] pick_id();
		if ($urandom_range(0, 3) == 0)
			return $urandom();
		return ID_W'($urandom_range(0, 15));
	endfunction

	task automatic evaluate_request(input logic op, input logic [SLOT_W-1:0] slot,
		input logic [ID_W-1:0] id, input logic [TAG_W-1:0] tag,
		input logic [PERM_W-1:0] perms, input logic last);
		decision_t d;
		logic      mask_ok;
		if (op == OP_LOAD) begin
			if (int'(slot) < SLOTS)
				member_gid[slot] = id;
			return;
		end
		case (tag) inside
			TAG_OWNER: begin
				owner_seen = 1'b1;
				owner_ok   = op_granted(perms);
			end
			TAG_NAMED_USER: begin
				if (id == req_uid) begin
					named_seen = 1'b1;
					named_ok   = op_granted(perms);
				end
			end
			TAG_OWNING_GRP, TAG_NAMED_GRP: begin
				if (is_member(tag == TAG_OWNING_GRP ? own_gid : id)) begin
					grp_seen = 1'b1;
					grp_ok   = grp_ok | op_granted(perms);
				end
			end
			TAG_MASK: mask_perms = perms;
			TAG_OTHER: begin
				other_seen = 1'b1;
				other_ok   = op_granted(perms);
			end
			default: ;
		endcase
		if (!last)
			return;
		mask_ok = op_granted(mask_perms);
		if (req_uid == own_uid) begin
			d.allowed = owner_seen ? owner_ok : op_granted(mode_bits[OWNER_SHIFT +: PERM_W]);
			d.reason  = d.allowed ? RSN_NONE : RSN_OWNER_DENIED;
		end else if (named_seen) begin
			d.allowed = named_ok && mask_ok;
			d.reason  = d.allowed ? RSN_NONE : RSN_LIST_DENIED;
		end else if (grp_seen) begin
			d.allowed = grp_ok && mask_ok;
			d.reason  = d.allowed ? RSN_NONE : RSN_LIST_DENIED;
		end else begin
			d.allowed = other_seen && other_ok;
			if (d.allowed)
				d.reason = RSN_NONE;
			else if (op_granted(mode_bits[GROUP_SHIFT +: PERM_W]))
				d.reason = RSN_GROUP_MISSING;
			else
				d.reason = RSN_OTHER_DENIED;
		end
		clear_findings();
		decision_q.push_back(d);
	endtask

	task automatic send_request(input logic op, input logic [SLOT_W-1:0] slot,
		input logic [ID_W-1:0] id, input logic [TAG_W-1:0] tag,
		input logic [PERM_W-1:0] perms, input logic last);
		if (idle_on && $urandom_range(0, 6) == 0) begin
			s_axis_tvalid <= 1'b0;
			repeat ($urandom_range(1, 13)) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tuser  <= op;
		s_axis_tlast  <= last;
		s_axis_tdata  <= {{PAD_W{1'b0}}, perms, tag, id, slot};
		@(posedge clk);
		while (!s_axis_tready) @(posedge clk);
		evaluate_request(op, slot, id, tag, perms, last);
		sent_cnt++;
	endtask

	task automatic send_entry(input logic [TAG_W-1:0] tag, input logic [ID_W-1:0] id,
		input logic [PERM_W-1:0] perms, input logic last);
		send_request(OP_ENTRY, SLOT_W'($urandom_range(0, 15)), id, tag, perms, last);
	endtask

	task automatic send_load(input logic [SLOT_W-1:0] slot, input logic [ID_W-1:0] id,
		input logic last);
		send_request(OP_LOAD, slot, id, TAG_W'($urandom_range(0, 7)),
			PERM_W'($urandom_range(0, 7)), last);
	endtask

	task automatic wait_idle();
		s_axis_tvalid <= 1'b0;
		while (decision_q.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		case (idx)
			REG_REQUEST_OP:     req_op    = val[OPSEL_W-1:0];
			REG_REQUESTER_UID:  req_uid   = val[ID_W-1:0];
			REG_FILE_OWNER_UID: own_uid   = val[ID_W-1:0];
			REG_FILE_GROUP_GID: own_gid   = val[ID_W-1:0];
			REG_FILE_MODE_BITS: mode_bits = val[MODE_W-1:0];
			REG_GROUP_COUNT:    grp_count = val[COUNT_W-1:0];
			default: ;
		endcase
	endtask

	task automatic set_config(input logic [OPSEL_W-1:0] op, input logic [ID_W-1:0] uid,
		input logic [ID_W-1:0] owner, input logic [ID_W-1:0] gid,
		input logic [MODE_W-1:0] mode, input logic [COUNT_W-1:0] count);
		wait_idle();
		write_reg(REG_REQUEST_OP, CFG_DATA_W'(op));
		write_reg(REG_REQUESTER_UID, uid);
		write_reg(REG_FILE_OWNER_UID, owner);
		write_reg(REG_FILE_GROUP_GID, gid);
		write_reg(REG_FILE_MODE_BITS, CFG_DATA_W'(mode));
		write_reg(REG_GROUP_COUNT, CFG_DATA_W'(count));
		cfg_valid <= 1'b0;
	endtask

	task automatic random_config();
		logic [ID_W-1:0] uid;
		uid = pick_id();
		set_config(OPSEL_W'($urandom_range(0, 3)), uid,
			($urandom_range(0, 9) < 3) ? uid : pick_id(),
			($urandom_range(0, 1) == 0) ? member_gid[$urandom_range(0, SLOTS-1)] : pick_id(),
			MODE_W'($urandom_range(0, 511)), COUNT_W'($urandom_range(0, 31)));
	endtask

	task automatic send_random_list(input int len);
		logic [TAG_W-1:0] tag;
		logic [ID_W-1:0]  id;
		int               r;
		for (int i = 0; i < len; i++) begin
			if ($urandom_range(0, 11) == 0)
				send_load(SLOT_W'($urandom_range(0, SLOTS-1)), pick_id(),
					1'($urandom_range(0, 1)));
			r = $urandom_range(0, 99);
			if (r < 14)
				tag = TAG_OWNER;
			else if (r < 32)
				tag = TAG_NAMED_USER;
			else if (r < 48)
				tag = TAG_OWNING_GRP;
			else if (r < 64)
				tag = TAG_NAMED_GRP;
			else if (r < 78)
				tag = TAG_MASK;
			else if (r < 94)
				tag = TAG_OTHER;
			else
				tag = (r < 97) ? TAG_IGNORED : TAG_RESERVED;
			case (tag)
				TAG_NAMED_USER: id = ($urandom_range(0, 1) == 0) ? req_uid : pick_id();
				TAG_NAMED_GRP: begin
					if ($urandom_range(0, 1) == 0)
						id = member_gid[$urandom_range(0, SLOTS-1)];
					else
						id = pick_id();
				end
				default: id = pick_id();
			endcase
			send_entry(tag, id, PERM_W'($urandom_range(0, 7)),
				(i == len - 1) || ($urandom_range(0, 19) == 0));
		end
	endtask

	task automatic load_group_table();
		for (int s = 0; s < SLOTS; s++)
			send_load(SLOT_W'(s), (s == 0) ? '0 : (s == SLOTS - 1) ? '1 : pick_id(),
				(s % 2) == 1);
	endtask

	task automatic check_directed_cases();
		set_config(REQ_READ, 32'd100, 32'd100, '1, 9'o700, 5'd16);
		send_entry(TAG_IGNORED, '0, 3'b000, 1'b1);
		send_entry(TAG_OWNER, 32'd100, 3'b011, 1'b1);
		send_entry(TAG_OWNER, '0, 3'b000, 1'b0);
		send_entry(TAG_OWNER, '1, 3'b111, 1'b1);

		set_config(REQ_WRITE, '1, '0, '1, 9'o020, 5'd16);
		send_entry(TAG_NAMED_USER, '1, 3'b111, 1'b0);
		send_entry(TAG_MASK, '0, 3'b101, 1'b1);
		send_entry(TAG_OWNING_GRP, '0, 3'b010, 1'b1);
		send_entry(TAG_NAMED_GRP, 32'h8000_0001, 3'b111, 1'b0);
		send_entry(TAG_OTHER, '0, 3'b010, 1'b1);
		send_load('0, '0, 1'b1);
		send_entry(TAG_RESERVED, '0, 3'b000, 1'b1);

		set_config(REQ_UNDEFINED, 32'd5, 32'd6, '0, 9'o777, 5'd31);
		send_entry(TAG_OTHER, '0, 3'b111, 1'b1);
		send_entry(TAG_NAMED_USER, 32'd5, 3'b111, 1'b1);
		send_entry(TAG_NAMED_GRP, '0, 3'b111, 1'b1);

		set_config(REQ_EXEC, 32'd7, 32'd8, '0, 9'o000, 5'd0);
		send_entry(TAG_OWNING_GRP, '0, 3'b111, 1'b0);
		send_entry(TAG_OTHER, '1, 3'b001, 1'b1);
		send_entry(TAG_MASK, '0, 3'b000, 1'b0);
		send_entry(TAG_OTHER, '0, 3'b000, 1'b1);
	endtask

	task automatic run_random_lists();
		int stop_at;
		stop_at = sent_cnt + RANDOM_ITEMS;
		while (sent_cnt < stop_at) begin
			idle_on = ($urandom_range(0, 4) != 0);
			random_config();
			repeat ($urandom_range(5, 30)) send_random_list($urandom_range(1, 8));
		end
	endtask

	task automatic check_backpressure();
		idle_on = 1'b1;
		random_config();
		hold_len = HOLD_CYCLES;
		repeat (40) send_random_list($urandom_range(1, 3));
		wait_idle();
		repeat (10) send_random_list($urandom_range(1, 4));
	endtask

	task automatic run_back_to_back();
		idle_on = 1'b0;
		random_config();
		repeat (60) send_random_list($urandom_range(1, 4));
	endtask

	// receiver: random stall bursts, plus the long hold-off on request
	initial begin
		m_axis_tready = 1'b0;
		forever begin
			@(posedge clk);
			if (hold_len > 0) begin
				m_axis_tready <= 1'b0;
				repeat (hold_len) @(posedge clk);
				hold_len = 0;
				m_axis_tready <= 1'b1;
			end else if (idle_on && $urandom_range(0, 5) == 0) begin
				m_axis_tready <= 1'b0;
				repeat ($urandom_range(1, 13)) @(posedge clk);
				m_axis_tready <= 1'b1;
			end else begin
				m_axis_tready <= 1'b1;
			end
		end
	end

	always @(posedge clk) begin : score_decision
		decision_t want;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (decision_q.size() == 0) begin
				$error("unexpected decision: allowed %0b reason %0d",
					m_axis_tdata[0], m_axis_tdata[3:1]);
				error_cnt++;
			end else begin
				want = decision_q.pop_front();
				if (m_axis_tdata[0] !== want.allowed) begin
					$error("allowed: expected %0b, got %0b", want.allowed, m_axis_tdata[0]);
					error_cnt++;
				end
				if (m_axis_tdata[3:1] !== want.reason) begin
					$error("reason: expected %0d, got %0d", want.reason, m_axis_tdata[3:1]);
					error_cnt++;
				end
			end
		end
	end

	initial begin
		#20_000_000;
		$display("Some tests failed");
		$finish;
	end

	initial begin
		arst_n        = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata  = '0;
		s_axis_tuser  = 1'b0;
		s_axis_tlast  = 1'b0;
		cfg_valid     = 1'b0;
		cfg_index     = '0;
		cfg_data      = '0;
		req_op        = REQ_READ;
		req_uid       = '0;
		own_uid       = '0;
		own_gid       = '0;
		mode_bits     = '0;
		grp_count     = '0;
		clear_findings();
		idle_on   = 1'b1;
		hold_len  = 0;
		sent_cnt  = 0;
		error_cnt = 0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		load_group_table();
		check_directed_cases();
		run_random_lists();
		check_backpressure();
		run_back_to_back();
		wait_idle();

		if (error_cnt == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule
